@@ sv/lpm_pkg.sv @@
package lpm_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned PORT_W = 8;
  localparam int unsigned CNT_W  = 7;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } route_t;

  // search state handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic              hit;
    logic [IDX_W-1:0]  best_idx;
    logic [ADDR_W-1:0] best_mask;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } token_t;

endpackage

@@ sv/lpm_if.sv @@
interface lpm_req_if;
  import lpm_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [IDX_W-1:0]  entry_index;
  logic [ADDR_W-1:0] route_prefix;
  logic [ADDR_W-1:0] route_mask;
  logic [ADDR_W-1:0] route_next_hop;
  logic [PORT_W-1:0] route_port;
  logic [ADDR_W-1:0] lookup_address;

  modport source (
    output valid, command, entry_index, route_prefix, route_mask,
           route_next_hop, route_port, lookup_address,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, route_prefix, route_mask,
           route_next_hop, route_port, lookup_address,
    output ready
  );
endinterface

interface lpm_rsp_if;
  import lpm_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [IDX_W-1:0]  match_index;
  logic [ADDR_W-1:0] hop_address;
  logic [PORT_W-1:0] out_port;

  modport source (
    output valid, found, match_index, hop_address, out_port,
    input  ready
  );
  modport sink (
    input  valid, found, match_index, hop_address, out_port,
    output ready
  );
endinterface

interface lpm_cfg_if;
  import lpm_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ sv/lpm_cell.sv @@
module lpm_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [lpm_pkg::IDX_W-1:0] wr_index,
  input  lpm_pkg::route_t          wr_route,
  input  logic [lpm_pkg::CNT_W-1:0] route_count,
  input  lpm_pkg::token_t          tok_in,
  output lpm_pkg::token_t          tok_out
);
  import lpm_pkg::*;

  route_t ent;
  token_t tok_next;
  logic   in_use;
  logic   hit_here;
  logic   take;

  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_index) == INDEX)) begin
      ent <= wr_route;
    end
  end

  assign in_use   = 32'(route_count) > INDEX;
  assign hit_here = in_use && ((tok_in.addr & ent.mask) == ent.prefix);
  // strictly longer mask replaces, so a tie keeps the lower slot
  assign take     = hit_here && (!tok_in.hit || (ent.mask > tok_in.best_mask));

  always_comb begin
    tok_next = tok_in;
    if (take) begin
      tok_next.hit       = 1'b1;
      tok_next.best_idx  = IDX_W'(INDEX);
      tok_next.best_mask = ent.mask;
      tok_next.hop       = ent.hop;
      tok_next.port      = ent.port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

@@ sv/longest_prefix_match_table_core.sv @@
// channel | dir | payload                                              | handshake
// cfg     | in  | data = route_count                                   | valid/ready
// req     | in  | command, entry_index, route_*, lookup_address        | valid/ready
// rsp     | out | found, match_index, hop_address, out_port            | valid/ready
//
// a write item updates its cell at acceptance; its all-zero result shows the next cycle
// a lookup walks the row of ROUTE_DEPTH cells, one cell per cycle, then loads the
// output register; one lookup in the row at a time
// reset clears route_count, busy, the row's valid bits and the output valid bit;
// table contents and the output data stay undefined until written
// req is taken only with no lookup in the row and the output register free or emptying
module longest_prefix_match_table_core #(
  parameter int unsigned ROUTE_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  lpm_cfg_if.sink   cfg,
  lpm_req_if.sink   req,
  lpm_rsp_if.source rsp
);
  import lpm_pkg::*;

  logic              busy;
  logic [CNT_W-1:0]  route_count;
  logic              out_valid;
  logic              out_found;
  logic [IDX_W-1:0]  out_index;
  logic [ADDR_W-1:0] out_hop;
  logic [PORT_W-1:0] out_port;

  logic   req_acc;
  logic   wr_en;
  logic   lookup_en;
  route_t wr_route;
  token_t chain [ROUTE_DEPTH+1];
  token_t tail;
  logic [ROUTE_DEPTH:0] tok_valids;

  assign cfg.ready = 1'b1;
  assign req.ready = !busy && (!out_valid || rsp.ready);
  assign req_acc   = req.valid && req.ready;
  assign wr_en     = req_acc && (req.command == CMD_WRITE);
  assign lookup_en = req_acc && (req.command == CMD_LOOKUP);

  assign wr_route.prefix = req.route_prefix;
  assign wr_route.mask   = req.route_mask;
  assign wr_route.hop    = req.route_next_hop;
  assign wr_route.port   = req.route_port;

  always_comb begin
    chain[0]           = '0;
    chain[0].valid     = lookup_en;
    chain[0].addr      = req.lookup_address;
  end

  for (genvar i = 0; i < ROUTE_DEPTH; i++) begin : g_cell
    lpm_cell #(.INDEX(i)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .wr_en       (wr_en),
      .wr_index    (req.entry_index),
      .wr_route    (wr_route),
      .route_count (route_count),
      .tok_in      (chain[i]),
      .tok_out     (chain[i+1])
    );
  end

  for (genvar i = 0; i <= ROUTE_DEPTH; i++) begin : g_vld
    assign tok_valids[i] = chain[i].valid;
  end

  assign tail = chain[ROUTE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      out_valid   <= 1'b0;
      route_count <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        route_count <= cfg.data;
      end
      if (lookup_en) begin
        busy <= 1'b1;
      end else if (tail.valid) begin
        busy <= 1'b0;
      end
      if (wr_en || tail.valid) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      out_found <= 1'b0;
      out_index <= '0;
      out_hop   <= '0;
      out_port  <= '0;
    end else if (tail.valid) begin
      out_found <= tail.hit;
      out_index <= tail.best_idx;
      out_hop   <= tail.hop;
      out_port  <= tail.port;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.found       = out_found;
  assign rsp.match_index = out_index;
  assign rsp.hop_address = out_hop;
  assign rsp.out_port    = out_port;

  a_one_lookup: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valids))
    else $error("more than one lookup in the cell row");

  a_tail_slot_free: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> (busy && !out_valid))
    else $error("lookup finished with output register occupied or not busy");

  a_done_shows: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> out_valid)
    else $error("lookup ended without a result");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (out_valid && !out_found && (out_index == '0)))
    else $error("write item result not zero");

endmodule
